>>> src/pfi_pkg.sv
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared types and constants for the packet-to-flit injector.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int unsigned QUEUE_DEPTH  = 8;
  localparam int unsigned QIDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MAX_FLITS    = 32;
  localparam int unsigned NODE_ID_BITS = 8;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned SEQ_W        = 5;
  localparam int unsigned KIND_W       = 2;

  // bus widths
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned S_USER_W = 1;
  localparam int unsigned M_DATA_W = 56;
  localparam int unsigned M_USER_W = 3;

  // flit kinds
  localparam logic [KIND_W-1:0] KIND_HEAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BODY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TAIL = 2'd2;

  typedef struct packed {
    logic [NODE_ID_BITS-1:0] src;
    logic [NODE_ID_BITS-1:0] dst;
    logic [TIME_BITS-1:0]    stamp;
    logic [LEN_W-1:0]        len;
    logic                    low_volt;
  } pfi_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic step;  // take the offered item and load the result register
  } pfi_cmd_t;

endpackage

>>> src/pfi_ctrl.sv
// ----------------------------------------------------------------------------
// pfi_ctrl
// Handshake controller: idle / result-held state machine.
// ----------------------------------------------------------------------------
module pfi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output pfi_pkg::pfi_cmd_t cmd_o
);
  import pfi_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_q, state_d;

  // result register frees up in the same cycle it is taken
  assign s_axis_tready = (state_q == ST_IDLE) || m_axis_tready;
  assign m_axis_tvalid = (state_q == ST_HOLD);
  assign cmd_o.step    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.step) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (cmd_o.step)         state_d = ST_HOLD;
        else if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // an accepted item always leaves a result behind
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // a stalled result blocks the input side
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !cmd_o.step)
    else $error("result overwritten while stalled");

  // a taken result with nothing new behind it empties the output
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !cmd_o.step) |=> !m_axis_tvalid)
    else $error("result repeated");

endmodule

>>> src/pfi_datapath.sv
// ----------------------------------------------------------------------------
// pfi_datapath
// Packet queue, flit sequencing, request level and result register.
// ----------------------------------------------------------------------------
module pfi_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfi_pkg::pfi_cmd_t             cmd_i,
  input  logic [pfi_pkg::S_DATA_W-1:0]  s_data_i,
  input  logic [pfi_pkg::S_USER_W-1:0]  s_user_i,
  output logic [pfi_pkg::M_DATA_W-1:0]  m_data_o,
  output logic [pfi_pkg::M_USER_W-1:0]  m_user_o
);
  import pfi_pkg::*;

  pfi_entry_t              store_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [LEN_W-1:0]        rem_q, rem_d;
  logic                    level_q, level_d;

  // unpacked input
  logic                    pkt_valid, ack_level;
  logic [LEN_W-1:0]        len_raw, len_sat;
  pfi_entry_t              new_entry;

  logic                    full, do_push, do_send, pop;
  logic [CNT_W:0]          slot_sum;
  logic [QIDX_W-1:0]       tail_idx;
  logic [CNT_W-1:0]        count_mid;
  pfi_entry_t              front;
  logic [LEN_W-1:0]        rem_eff, rem_next, seq_full;
  logic [KIND_W-1:0]       kind;

  assign pkt_valid          = s_user_i[0];
  assign new_entry.src      = s_data_i[7:0];
  assign new_entry.dst      = s_data_i[15:8];
  assign new_entry.stamp    = s_data_i[47:16];
  assign len_raw            = s_data_i[53:48];
  assign new_entry.low_volt = s_data_i[54];
  assign ack_level          = s_data_i[55];

  // zero length means one flit; overlong saturates
  always_comb begin
    if (len_raw == '0)                     len_sat = LEN_W'(1);
    else if (len_raw > LEN_W'(MAX_FLITS))  len_sat = LEN_W'(MAX_FLITS);
    else                                   len_sat = len_raw;
  end
  assign new_entry.len = len_sat;

  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push  = pkt_valid && !full;
  assign slot_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  assign tail_idx = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                  ? QIDX_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH))
                  : QIDX_W'(slot_sum);
  assign count_mid = count_q + CNT_W'(do_push);

  // empty queue plus push: the new packet is the front this cycle
  assign front   = (count_q == '0) ? new_entry : store_q[head_q];
  assign do_send = (ack_level == level_q) && (count_mid != '0);

  assign rem_eff  = (rem_q == '0 || rem_q > front.len) ? front.len : rem_q;
  assign rem_next = rem_eff - LEN_W'(1);
  assign seq_full = front.len - rem_eff;
  assign pop      = do_send && (rem_next == '0);

  always_comb begin
    if (rem_eff == front.len)      kind = KIND_HEAD;
    else if (rem_eff == LEN_W'(1)) kind = KIND_TAIL;
    else                           kind = KIND_BODY;
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rem_d   = rem_q;
    level_d = level_q;
    if (cmd_i.step) begin
      count_d = count_mid - CNT_W'(pop);
      if (do_send) begin
        rem_d   = rem_next;
        level_d = ~level_q;
      end
      if (pop) begin
        head_d = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rem_q   <= '0;
      level_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && do_push) begin
      store_q[tail_idx] <= new_entry;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      m_data_o[0]     <= level_d;
      m_data_o[8:1]   <= do_send ? front.src   : '0;
      m_data_o[16:9]  <= do_send ? front.dst   : '0;
      m_data_o[48:17] <= do_send ? front.stamp : '0;
      m_data_o[53:49] <= do_send ? seq_full[SEQ_W-1:0] : '0;
      m_data_o[54]    <= do_send && front.low_volt;
      m_data_o[55]    <= pkt_valid && full;
      m_user_o[0]     <= do_send;
      m_user_o[2:1]   <= do_send ? kind : KIND_HEAD;
    end
  end

endmodule

>>> src/packet_to_flit_injector_top.sv
// ----------------------------------------------------------------------------
// packet_to_flit_injector_top
// Network-interface transmitter: queues packets, sends flits under an
// alternating-bit request/acknowledge scheme.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake              Carries
// s_axis   in   tvalid/tready          one tick: new packet (optional) + ack level
// m_axis   out  tvalid/tready          one result per tick: flit, req level, drop
//
// Each transfer in yields exactly one transfer out, offered in the next cycle.
// One item per cycle sustained while m_axis_tready is high; the queue state
// and request level update in the accepting cycle, and the result register
// decouples the two sides.
// Reset (rst_ni low, async) empties the queue, clears the flit counter and
// drops the request level to 0. Queue contents are not cleared.
// A stalled result holds; s_axis_tready then falls until it is taken.
// ----------------------------------------------------------------------------
module packet_to_flit_injector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: pkt_source[7:0], pkt_dest[15:8], pkt_time[47:16],
  //        pkt_length[53:48], pkt_low_volt[54], ack_level[55]
  input  logic [pfi_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // tuser: packet_valid[0]
  input  logic [pfi_pkg::S_USER_W-1:0]  s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: req_level[0], flit_source[8:1], flit_dest[16:9], flit_time[48:17],
  //        flit_seq[53:49], flit_low_volt[54], packet_dropped[55]
  output logic [pfi_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // tuser: flit_valid[0], flit_kind[2:1]
  output logic [pfi_pkg::M_USER_W-1:0]  m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);
  import pfi_pkg::*;

  pfi_cmd_t cmd;

  // handshake sequencing
  pfi_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  // queue, flit sequencing and result register
  pfi_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .s_data_i (s_axis_tdata),
    .s_user_i (s_axis_tuser),
    .m_data_o (m_axis_tdata),
    .m_user_o (m_axis_tuser)
  );

endmodule
